// ===== sv/dps_pkg.sv =====
// ----------------------------------------------------------------------------
// dps_pkg
// shared widths, defaults, port structs and sequencer states for the
// permutation-sum determinant core
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

  localparam int MAX_SIZE_DEF = 4;   // default matrix order limit
  localparam int SIZE_W       = 3;   // matrix_size register width
  localparam int ELEM_W       = 12;  // one matrix entry
  localparam int DET_W        = 64;  // determinant width
  localparam int ADDR_W       = 5;   // store address, covers up to 5x5
  localparam int IN_TDATA_W   = 16;  // entry padded to whole bytes

  // store write request from the front end
  typedef struct packed {
    logic                     en;
    logic [ADDR_W-1:0]        addr;
    logic signed [ELEM_W-1:0] data;
  } dps_wr_t;

  // queued determinant job
  typedef struct packed {
    logic              valid;
    logic [SIZE_W-1:0] size;
  } dps_job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } dps_state_t;

endpackage

`default_nettype wire

// ===== sv/dps_front.sv =====
// ----------------------------------------------------------------------------
// dps_front
// accepts entries, counts them into the store and queues a job per matrix
// ----------------------------------------------------------------------------
`default_nettype none

module dps_front #(
  parameter int MAX_SIZE = dps_pkg::MAX_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dps_pkg::SIZE_W-1:0]      cfg_wr_data,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dps_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            back_busy,
  input  logic                            job_pop,
  output dps_pkg::dps_wr_t                wr,
  output dps_pkg::dps_job_t               job
);

  localparam int LCW = $clog2(MAX_SIZE * MAX_SIZE + 1);

  logic [dps_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic [LCW-1:0]             load_r, load_nxt;
  logic                       job_valid_r, job_valid_nxt;
  logic [dps_pkg::SIZE_W-1:0] job_size_r, job_size_nxt;

  logic [dps_pkg::SIZE_W-1:0] eff_size;
  logic [LCW-1:0]             total;
  logic [LCW-1:0]             idx;
  logic                       accept;

  // zero counts as one, anything above the limit as the limit
  always_comb begin
    if (size_r == '0) begin
      eff_size = dps_pkg::SIZE_W'(1);
    end else if (size_r > dps_pkg::SIZE_W'(MAX_SIZE)) begin
      eff_size = dps_pkg::SIZE_W'(MAX_SIZE);
    end else begin
      eff_size = size_r;
    end
  end

  assign total     = LCW'(eff_size) * LCW'(eff_size);
  assign in_tready = !job_valid_r && !back_busy;
  assign accept    = in_tvalid && in_tready;
  assign idx       = (load_r >= total) ? '0 : load_r;

  always_comb begin
    size_nxt      = size_r;
    load_nxt      = load_r;
    job_valid_nxt = job_valid_r;
    job_size_nxt  = job_size_r;
    if (job_pop) begin
      job_valid_nxt = 1'b0;
    end
    if (cfg_wr_en) begin
      size_nxt = cfg_wr_data;
      load_nxt = '0;
    end else if (accept) begin
      if (idx + LCW'(1) == total) begin
        load_nxt      = '0;
        job_valid_nxt = 1'b1;
        job_size_nxt  = eff_size;
      end else begin
        load_nxt = idx + LCW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= dps_pkg::SIZE_W'(3);
      load_r      <= '0;
      job_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      load_r      <= load_nxt;
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_size_r <= job_size_nxt;
  end

  always_comb begin
    wr.en    = accept;
    wr.addr  = dps_pkg::ADDR_W'(idx);
    wr.data  = in_tdata[dps_pkg::ELEM_W-1:0];
    job.valid = job_valid_r;
    job.size  = job_size_r;
  end

endmodule

`default_nettype wire

// ===== sv/dps_back.sv =====
// ----------------------------------------------------------------------------
// dps_back
// entry store and permutation sequencer: each row product takes a select
// and a multiply state, permutations walked as a mixed-radix lehmer code
// ----------------------------------------------------------------------------
`default_nettype none

module dps_back #(
  parameter int MAX_SIZE = dps_pkg::MAX_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dps_pkg::dps_wr_t              wr,
  input  dps_pkg::dps_job_t             job,
  output logic                          job_pop,
  output logic                          back_busy,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [dps_pkg::DET_W-1:0]     out_tdata
);

  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = (MAX_SIZE > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SW    = dps_pkg::SIZE_W;
  localparam int DW    = dps_pkg::DET_W;
  localparam int EW    = dps_pkg::ELEM_W;

  logic signed [EW-1:0] store [DEPTH];
  logic signed [EW-1:0] rd_data_r;

  dps_pkg::dps_state_t  state_r, state_nxt;
  logic [SW-1:0]        n_r, n_nxt;
  logic [CW-1:0]        dig_r [MAX_SIZE];
  logic [CW-1:0]        dig_nxt [MAX_SIZE];
  logic [CW-1:0]        row_r, row_nxt;
  logic [AW-1:0]        base_r, base_nxt;
  logic [MAX_SIZE-1:0]  used_r, used_nxt;
  logic signed [DW-1:0] prod_r, prod_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DW-1:0]        out_data_r, out_data_nxt;

  logic [CW-1:0]        sel_c;
  logic [CW:0]          zcnt;
  logic                 found;
  logic [AW-1:0]        rd_addr;
  logic                 par;
  logic                 carry;
  logic                 last_row;
  logic                 out_free;

  assign out_free = !out_valid_r || out_tready;
  assign last_row = ({{(SW > CW ? SW - CW : 1){1'b0}}, row_r} ==
                     (SW > CW ? SW - CW + CW : CW + 1)'(n_r - SW'(1)));

  // column for this row: the digit-th free column
  always_comb begin
    sel_c = '0;
    zcnt  = '0;
    found = 1'b0;
    for (int c = 0; c < MAX_SIZE; c++) begin
      if (SW'(c) < n_r && !used_r[c] && !found) begin
        if (zcnt == (CW + 1)'(dig_r[row_r])) begin
          sel_c = CW'(c);
          found = 1'b1;
        end
        zcnt = zcnt + (CW + 1)'(1);
      end
    end
  end

  assign rd_addr = base_r + AW'(sel_c);

  // lehmer digit sum equals the inversion count
  always_comb begin
    par = 1'b0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      par = par ^ dig_r[i][0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dps_pkg::ST_IDLE: if (job.valid) state_nxt = dps_pkg::ST_SEL;
      dps_pkg::ST_SEL:  state_nxt = dps_pkg::ST_MUL;
      dps_pkg::ST_MUL:  state_nxt = last_row ? dps_pkg::ST_ACC : dps_pkg::ST_SEL;
      dps_pkg::ST_ACC:  state_nxt = carry ? dps_pkg::ST_OUT : dps_pkg::ST_SEL;
      dps_pkg::ST_OUT:  if (out_free) state_nxt = dps_pkg::ST_IDLE;
      default:          state_nxt = dps_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    n_nxt         = n_r;
    row_nxt       = row_r;
    base_nxt      = base_r;
    used_nxt      = used_r;
    prod_nxt      = prod_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    job_pop       = 1'b0;
    carry         = 1'b1;
    for (int i = 0; i < MAX_SIZE; i++) begin
      dig_nxt[i] = dig_r[i];
    end
    unique case (state_r)
      dps_pkg::ST_IDLE: begin
        if (job.valid) begin
          job_pop  = 1'b1;
          n_nxt    = job.size;
          acc_nxt  = '0;
          row_nxt  = '0;
          base_nxt = '0;
          used_nxt = '0;
          prod_nxt = DW'(1);
          for (int i = 0; i < MAX_SIZE; i++) begin
            dig_nxt[i] = '0;
          end
        end
      end
      dps_pkg::ST_SEL: begin
        used_nxt = used_r | (MAX_SIZE'(1) << sel_c);
      end
      dps_pkg::ST_MUL: begin
        prod_nxt = DW'(prod_r * DW'(rd_data_r));
        row_nxt  = row_r + CW'(1);
        base_nxt = base_r + AW'(n_r);
      end
      dps_pkg::ST_ACC: begin
        acc_nxt = par ? (acc_r - prod_r) : (acc_r + prod_r);
        for (int i = MAX_SIZE - 1; i >= 0; i--) begin
          if (SW'(i) < n_r && carry) begin
            if (SW'(dig_r[i]) == n_r - SW'(1) - SW'(i)) begin
              dig_nxt[i] = '0;
            end else begin
              dig_nxt[i] = dig_r[i] + CW'(1);
              carry      = 1'b0;
            end
          end
        end
        row_nxt  = '0;
        base_nxt = '0;
        used_nxt = '0;
        prod_nxt = DW'(1);
      end
      dps_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      store[wr.addr[AW-1:0]] <= wr.data;
    end
    if (state_r == dps_pkg::ST_SEL) begin
      rd_data_r <= store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dps_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      acc_r       <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    used_r     <= used_nxt;
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
    for (int i = 0; i < MAX_SIZE; i++) begin
      dig_r[i] <= dig_nxt[i];
    end
  end

  assign back_busy  = (state_r != dps_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/determinant_by_permutation_sum_core.sv =====
// ----------------------------------------------------------------------------
// determinant_by_permutation_sum_core
// leibniz determinant of a square matrix of up to MAX_SIZE rows
// ----------------------------------------------------------------------------
// usage
//   in_*  : one matrix entry per request, row-major, signed 12 bits in the
//           low bits of in_tdata; after the last of n*n entries the matrix
//           is handed to the sequencer
//   out_* : one determinant request per matrix, signed 64 bits
//   cfg_* : writing cfg_wr_data sets the order n (0 taken as 1, above
//           MAX_SIZE taken as MAX_SIZE) and restarts loading
// sequencing
//   an entry is taken when in_tvalid and in_tready are both high; after the
//   last entry the sequencer walks all n! permutations, and the single 64x12
//   multiplier folds in one row per select and multiply state pair
//   entries of the next matrix are refused until the sequencer finishes
// reset
//   n returns to 3, the load count clears and no result is pending;
//   the entry store is not cleared
// stalls
//   the result waits in an output register; the sequencer goes idle and
//   loading resumes while out_tready is low
// ----------------------------------------------------------------------------
`default_nettype none

module determinant_by_permutation_sum_core #(
  parameter int MAX_SIZE = dps_pkg::MAX_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [dps_pkg::SIZE_W-1:0]      cfg_wr_data,     // matrix_size
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [dps_pkg::IN_TDATA_W-1:0]  in_tdata,        // [11:0] elem_value
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dps_pkg::DET_W-1:0]       out_tdata        // [63:0] det_value
);

  dps_pkg::dps_wr_t  wr;
  dps_pkg::dps_job_t job;
  logic              job_pop;
  logic              back_busy;

  // front end: counting and the one-deep job queue
  dps_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .back_busy   (back_busy),
    .job_pop     (job_pop),
    .wr          (wr),
    .job         (job)
  );

  // back end: store, permutation walk and output register
  dps_back #(
    .MAX_SIZE (MAX_SIZE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr         (wr),
    .job        (job),
    .job_pop    (job_pop),
    .back_busy  (back_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== sv/dps_checker.sv =====
// ----------------------------------------------------------------------------
// dps_checker
// port-level checks for the determinant core
// ----------------------------------------------------------------------------
`default_nettype none

module dps_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [63:0] out_tdata
);

  // held result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // held result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result changed while stalled");

  // a result is only raised while loading is shut off
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result raised while loading open");

  // loading only shuts after an accepted entry
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(in_tvalid && in_tready))
    else $error("input closed without a request");

endmodule

bind determinant_by_permutation_sum_core dps_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
